// ===== design/vfs_pkg.sv =====
// Shared types, constants and command codes of the voxel falling-sand grid.
package vfs_pkg;

	localparam int GRID_EDGE_DEF = 16;
	localparam int ID_BITS_DEF   = 8;

	localparam logic [7:0] SAND_RESET = 8'd2;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;

	// probe codes; the first six double as neighbour mask bit positions
	typedef logic [3:0] probe_t;
	localparam probe_t PRB_XM  = 4'd0;
	localparam probe_t PRB_XP  = 4'd1;
	localparam probe_t PRB_ZP  = 4'd2;
	localparam probe_t PRB_ZM  = 4'd3;
	localparam probe_t PRB_YP  = 4'd4;
	localparam probe_t PRB_YM  = 4'd5;
	localparam probe_t PRB_C   = 4'd6;
	localparam probe_t PRB_BXP = 4'd7;
	localparam probe_t PRB_BXM = 4'd8;
	localparam probe_t PRB_BZP = 4'd9;
	localparam probe_t PRB_BZM = 4'd10;

	typedef logic [1:0] wsel_t;
	localparam wsel_t WS_ZERO = 2'd0;
	localparam wsel_t WS_REQ  = 2'd1;
	localparam wsel_t WS_SAND = 2'd2;

	typedef struct packed {
		logic   req_ready;
		logic   load;
		logic   rd_en;
		logic   wr_en;
		wsel_t  wsel;
		probe_t prb;
		logic   cap_rv;
		logic   cap_mask;
		logic   set_moved;
		logic   advance;
		logic   ld_rsp;
	} ctl_cmd_t;

	typedef struct packed {
		logic       req_valid;
		logic [1:0] req_cmd;
		logic       req_inside;
		logic       rd_nz;
		logic       rd_sand;
		logic       inb;
		logic       y_zero;
		logic       last_cell;
		logic       rsp_busy;
	} ctl_sts_t;

	// read probe order: center, then the six faces
	function automatic probe_t next_read_probe(input probe_t p);
		probe_t n;
		case (p)
			PRB_C:   n = PRB_XM;
			PRB_XM:  n = PRB_XP;
			PRB_XP:  n = PRB_ZP;
			PRB_ZP:  n = PRB_ZM;
			PRB_ZM:  n = PRB_YP;
			PRB_YP:  n = PRB_YM;
			default: n = PRB_YM;
		endcase
		return n;
	endfunction

	// fall probe order: below, below+x, below-x, below+z, below-z
	function automatic probe_t next_fall_probe(input probe_t p);
		probe_t n;
		case (p)
			PRB_YM:  n = PRB_BXP;
			PRB_BXP: n = PRB_BXM;
			PRB_BXM: n = PRB_BZP;
			default: n = PRB_BZM;
		endcase
		return n;
	endfunction

endpackage

// ===== design/vfs_if.sv =====
// Handshake channel interfaces: request, response and configuration write.
interface vfs_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [3:0] pos_x;
	logic [3:0] pos_y;
	logic [3:0] pos_z;
	logic [7:0] voxel_value;

	modport source (output valid, cmd, pos_x, pos_y, pos_z, voxel_value, input ready);
	modport sink (input valid, cmd, pos_x, pos_y, pos_z, voxel_value, output ready);
endinterface

interface vfs_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_value;
	logic [5:0] neighbour_mask;
	logic       moved_any;

	modport source (output valid, read_value, neighbour_mask, moved_any, input ready);
	modport sink (input valid, read_value, neighbour_mask, moved_any, output ready);
endinterface

interface vfs_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] wdata;

	modport source (output valid, wdata, input ready);
	modport sink (input valid, wdata, output ready);
endinterface

// ===== design/vfs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module vfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/vfs_ctrl.sv =====
// Controller state machine: sequences write, read-with-mask and sweep commands.
module vfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  vfs_pkg::ctl_sts_t sts,
	output vfs_pkg::ctl_cmd_t ctl
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WR   = 4'd1;
	localparam logic [3:0] S_RISS = 4'd2;
	localparam logic [3:0] S_RCAP = 4'd3;
	localparam logic [3:0] S_CISS = 4'd4;
	localparam logic [3:0] S_CCAP = 4'd5;
	localparam logic [3:0] S_FISS = 4'd6;
	localparam logic [3:0] S_FCAP = 4'd7;
	localparam logic [3:0] S_MVT  = 4'd8;
	localparam logic [3:0] S_MVS  = 4'd9;
	localparam logic [3:0] S_NEXT = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	logic [3:0]      state_q;
	vfs_pkg::probe_t prb_q;

	always_comb begin
		ctl      = '0;
		ctl.prb  = prb_q;
		ctl.wsel = vfs_pkg::WS_ZERO;
		case (state_q)
			S_IDLE: begin
				ctl.req_ready = 1'b1;
				ctl.load      = sts.req_valid;
			end
			S_WR: begin
				ctl.wr_en = 1'b1;
				ctl.wsel  = vfs_pkg::WS_REQ;
			end
			S_RISS, S_CISS, S_FISS: begin
				ctl.rd_en = 1'b1;
			end
			S_RCAP: begin
				ctl.cap_rv   = (prb_q == vfs_pkg::PRB_C);
				ctl.cap_mask = (prb_q != vfs_pkg::PRB_C);
			end
			S_MVT: begin
				ctl.wr_en     = 1'b1;
				ctl.wsel      = vfs_pkg::WS_SAND;
				ctl.set_moved = 1'b1;
			end
			S_MVS: begin
				ctl.wr_en = 1'b1;
				ctl.wsel  = vfs_pkg::WS_ZERO;
				ctl.prb   = vfs_pkg::PRB_C;
			end
			S_NEXT: begin
				ctl.advance = !sts.last_cell;
			end
			S_DONE: begin
				ctl.ld_rsp = !sts.rsp_busy;
			end
			default: begin
				ctl.req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prb_q   <= vfs_pkg::PRB_C;
		end else begin
			case (state_q)
				S_IDLE: begin
					prb_q <= vfs_pkg::PRB_C;
					if (sts.req_valid) begin
						case (sts.req_cmd)
							vfs_pkg::CMD_WRITE: state_q <= sts.req_inside ? S_WR : S_DONE;
							vfs_pkg::CMD_READ:  state_q <= sts.req_inside ? S_RISS : S_DONE;
							vfs_pkg::CMD_STEP:  state_q <= S_CISS;
							default:            state_q <= S_DONE;
						endcase
					end
				end
				S_WR: begin
					state_q <= S_DONE;
				end
				S_RISS: begin
					state_q <= S_RCAP;
				end
				S_RCAP: begin
					if (prb_q == vfs_pkg::PRB_YM) begin
						state_q <= S_DONE;
					end else begin
						prb_q   <= vfs_pkg::next_read_probe(prb_q);
						state_q <= S_RISS;
					end
				end
				S_CISS: begin
					state_q <= S_CCAP;
				end
				S_CCAP: begin
					if (sts.rd_sand && !sts.y_zero) begin
						prb_q   <= vfs_pkg::PRB_YM;
						state_q <= S_FISS;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_FISS: begin
					state_q <= S_FCAP;
				end
				S_FCAP: begin
					if (sts.inb && !sts.rd_nz) begin
						state_q <= S_MVT;
					end else if (prb_q == vfs_pkg::PRB_BZM) begin
						state_q <= S_NEXT;
					end else begin
						prb_q   <= vfs_pkg::next_fall_probe(prb_q);
						state_q <= S_FISS;
					end
				end
				S_MVT: begin
					state_q <= S_MVS;
				end
				S_MVS: begin
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					prb_q   <= vfs_pkg::PRB_C;
					state_q <= sts.last_cell ? S_DONE : S_CISS;
				end
				S_DONE: begin
					if (!sts.rsp_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.rd_en && ctl.wr_en))
		else $error("read and write issued in the same cycle");

	a_move_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MVT) |=> (state_q == S_MVS))
		else $error("target write not followed by source clear");

	a_rsp_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_rsp |-> !sts.rsp_busy)
		else $error("response register overwritten while held");

endmodule

// ===== design/vfs_dp.sv =====
// Datapath: coordinate registers, probe address generation, grid RAM, result registers.
module vfs_dp #(
	parameter int GRID_EDGE = vfs_pkg::GRID_EDGE_DEF,
	parameter int ID_BITS   = vfs_pkg::ID_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	vfs_req_if.sink           req,
	vfs_rsp_if.source         rsp,
	vfs_cfg_if.sink           cfg,
	input  vfs_pkg::ctl_cmd_t ctl,
	output vfs_pkg::ctl_sts_t sts
);

	localparam int CW    = $clog2(GRID_EDGE);
	localparam int DEPTH = GRID_EDGE * GRID_EDGE * GRID_EDGE;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [CW-1:0] CMAX  = CW'(GRID_EDGE - 1);
	localparam logic [AW-1:0] AREA  = AW'(GRID_EDGE * GRID_EDGE);
	localparam logic [AW-1:0] EDGEA = AW'(GRID_EDGE);

	logic [CW-1:0]      x_q, y_q, z_q;
	logic [7:0]         val_q;
	logic [7:0]         sand_q;
	logic [7:0]         rv_q;
	logic [5:0]         mask_q;
	logic               moved_q;
	logic               inb_q;
	logic               rsp_valid_q;
	logic [7:0]         rsp_rv_q;
	logic [5:0]         rsp_mask_q;
	logic               rsp_moved_q;

	logic [CW-1:0]      tx, ty, tz;
	logic               inb;
	logic               xlo, xhi, ylo, yhi, zlo, zhi;
	logic [AW-1:0]      addr;
	logic [ID_BITS-1:0] wdata;
	logic [ID_BITS-1:0] rdata;

	assign xlo = (x_q != '0);
	assign xhi = (x_q != CMAX);
	assign ylo = (y_q != '0);
	assign yhi = (y_q != CMAX);
	assign zlo = (z_q != '0);
	assign zhi = (z_q != CMAX);

	always_comb begin
		tx  = x_q;
		ty  = y_q;
		tz  = z_q;
		inb = 1'b0;
		case (ctl.prb)
			vfs_pkg::PRB_C: begin
				inb = 1'b1;
			end
			vfs_pkg::PRB_XM: begin
				tx  = x_q - CW'(1);
				inb = xlo;
			end
			vfs_pkg::PRB_XP: begin
				tx  = x_q + CW'(1);
				inb = xhi;
			end
			vfs_pkg::PRB_ZP: begin
				tz  = z_q + CW'(1);
				inb = zhi;
			end
			vfs_pkg::PRB_ZM: begin
				tz  = z_q - CW'(1);
				inb = zlo;
			end
			vfs_pkg::PRB_YP: begin
				ty  = y_q + CW'(1);
				inb = yhi;
			end
			vfs_pkg::PRB_YM: begin
				ty  = y_q - CW'(1);
				inb = ylo;
			end
			vfs_pkg::PRB_BXP: begin
				ty  = y_q - CW'(1);
				tx  = x_q + CW'(1);
				inb = ylo && xhi;
			end
			vfs_pkg::PRB_BXM: begin
				ty  = y_q - CW'(1);
				tx  = x_q - CW'(1);
				inb = ylo && xlo;
			end
			vfs_pkg::PRB_BZP: begin
				ty  = y_q - CW'(1);
				tz  = z_q + CW'(1);
				inb = ylo && zhi;
			end
			vfs_pkg::PRB_BZM: begin
				ty  = y_q - CW'(1);
				tz  = z_q - CW'(1);
				inb = ylo && zlo;
			end
			default: begin
				inb = 1'b0;
			end
		endcase
	end

	// x outermost, then y, then z in the linear layout
	assign addr = AW'(AW'(tx) * AREA) + AW'(AW'(ty) * EDGEA) + AW'(tz);

	always_comb begin
		case (ctl.wsel)
			vfs_pkg::WS_REQ:  wdata = ID_BITS'(val_q);
			vfs_pkg::WS_SAND: wdata = ID_BITS'(sand_q);
			default:          wdata = '0;
		endcase
	end

	vfs_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ctl.wr_en),
		.waddr (addr),
		.wdata (wdata),
		.re    (ctl.rd_en && inb),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sand_q <= vfs_pkg::SAND_RESET;
		end else if (cfg.valid) begin
			sand_q <= cfg.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (req.cmd == vfs_pkg::CMD_STEP) begin
				x_q <= '0;
				y_q <= '0;
				z_q <= '0;
			end else begin
				x_q <= CW'(req.pos_x);
				y_q <= CW'(req.pos_y);
				z_q <= CW'(req.pos_z);
			end
			val_q   <= req.voxel_value;
			rv_q    <= '0;
			mask_q  <= '0;
			moved_q <= 1'b0;
		end else if (ctl.advance) begin
			if (y_q == CMAX) begin
				y_q <= '0;
				if (z_q == CMAX) begin
					z_q <= '0;
					x_q <= x_q + CW'(1);
				end else begin
					z_q <= z_q + CW'(1);
				end
			end else begin
				y_q <= y_q + CW'(1);
			end
		end
		if (ctl.rd_en) begin
			inb_q <= inb;
		end
		if (ctl.cap_rv) begin
			rv_q <= 8'(rdata);
		end
		if (ctl.cap_mask) begin
			mask_q[ctl.prb[2:0]] <= inb_q && (rdata != '0);
		end
		if (ctl.set_moved) begin
			moved_q <= 1'b1;
		end
		if (ctl.ld_rsp) begin
			rsp_rv_q    <= rv_q;
			rsp_mask_q  <= mask_q;
			rsp_moved_q <= moved_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.ld_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign req.ready          = ctl.req_ready;
	assign cfg.ready          = 1'b1;
	assign rsp.valid          = rsp_valid_q;
	assign rsp.read_value     = rsp_rv_q;
	assign rsp.neighbour_mask = rsp_mask_q;
	assign rsp.moved_any      = rsp_moved_q;

	assign sts.req_valid  = req.valid;
	assign sts.req_cmd    = req.cmd;
	assign sts.req_inside = (32'(req.pos_x) < 32'(GRID_EDGE)) &&
	                        (32'(req.pos_y) < 32'(GRID_EDGE)) &&
	                        (32'(req.pos_z) < 32'(GRID_EDGE));
	assign sts.rd_nz      = (rdata != '0);
	assign sts.rd_sand    = (rdata != '0) && (16'(rdata) == 16'(sand_q));
	assign sts.inb        = inb_q;
	assign sts.y_zero     = !ylo;
	assign sts.last_cell  = (x_q == CMAX) && (y_q == CMAX) && (z_q == CMAX);
	assign sts.rsp_busy   = rsp_valid_q && !rsp.ready;

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> (32'(addr) < DEPTH))
		else $error("grid write outside the store");

endmodule

// ===== design/voxel_falling_sand_grid_top.sv =====
// From accept to response valid: an in-grid write passes the write state; a read issues and captures
// the center and then the six faces in turn; a step sweeps every cell of the grid.
// Every cell costs a center read of the grid RAM (issue, capture, advance); a falling
// voxel adds an issue and a capture per probe and, per move, a target write and a source clear.
// One item at a time; the next is accepted the cycle after the result is registered.
// Reset clears control and sets sand_id to 2; grid contents are undefined until written.
module voxel_falling_sand_grid_top #(
	parameter int GRID_EDGE = vfs_pkg::GRID_EDGE_DEF,
	parameter int ID_BITS   = vfs_pkg::ID_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	vfs_req_if.sink   req,
	vfs_rsp_if.source rsp,
	vfs_cfg_if.sink   cfg
);

	vfs_pkg::ctl_cmd_t ctl;
	vfs_pkg::ctl_sts_t sts;

	vfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	vfs_dp #(
		.GRID_EDGE (GRID_EDGE),
		.ID_BITS   (ID_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.ctl    (ctl),
		.sts    (sts)
	);

endmodule
